/* hdl/sis_pkg.sv */
// ----------------------------------------------------------------------------
// sis_pkg
// Shared types and constants for the stable insertion sorter: channel
// payloads, cell control word and controller states.
// ----------------------------------------------------------------------------
package sis_pkg;

   localparam int DEFAULT_MAX_RECORDS = 64;
   localparam int KEY_W               = 16;
   localparam int TAG_W               = 16;

   typedef struct packed {
      logic signed [KEY_W-1:0] sort_key;
      logic        [TAG_W-1:0] payload_tag;
      logic                    is_final;
   } req_payload_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] sorted_key;
      logic        [TAG_W-1:0] sorted_tag;
      logic                    end_of_set;
      logic                    overflowed;
   } rsp_payload_type;

   // Operation broadcast to every cell of the row
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_SHIFT_OUT
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic signed [KEY_W-1:0] new_key;
      logic        [TAG_W-1:0] new_tag;
   } cell_ctrl_type;

   typedef enum logic {
      ST_COLLECT,
      ST_DRAIN
   } state_type;

endpackage

/* hdl/sis_req_if.sv */
// ----------------------------------------------------------------------------
// sis_req_if
// Valid/ready channel carrying input records into the sorter.
// ----------------------------------------------------------------------------
interface sis_req_if;
   import sis_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/sis_rsp_if.sv */
// ----------------------------------------------------------------------------
// sis_rsp_if
// Valid/ready channel carrying sorted records out of the sorter.
// ----------------------------------------------------------------------------
interface sis_rsp_if;
   import sis_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/sis_cell.sv */
// ----------------------------------------------------------------------------
// sis_cell
// One storage cell of the sorting row. On insert it either keeps its record,
// takes its left neighbor's record or takes the new record; on shift-out it
// takes its right neighbor's record.
// ----------------------------------------------------------------------------
module sis_cell (
   input  logic                             clock,
   input  sis_pkg::cell_ctrl_type           ctrl,
   input  logic                             occupied,
   input  logic                             left_gt,
   input  logic signed [sis_pkg::KEY_W-1:0] left_key,
   input  logic        [sis_pkg::TAG_W-1:0] left_tag,
   input  logic signed [sis_pkg::KEY_W-1:0] right_key,
   input  logic        [sis_pkg::TAG_W-1:0] right_tag,
   output logic                             gt,
   output logic signed [sis_pkg::KEY_W-1:0] key,
   output logic        [sis_pkg::TAG_W-1:0] tag
);
   import sis_pkg::*;

   logic signed [KEY_W-1:0] key_ff, key_in;
   logic        [TAG_W-1:0] tag_ff, tag_in;

   // Empty cells and strictly greater keys lie behind the insertion point
   assign gt  = !occupied || (key_ff > ctrl.new_key);
   assign key = key_ff;
   assign tag = tag_ff;

   // Select the next record for this cell
   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (gt && left_gt) begin
               key_in = left_key;
               tag_in = left_tag;
            end else if (gt) begin
               key_in = ctrl.new_key;
               tag_in = ctrl.new_tag;
            end
         end
         OP_SHIFT_OUT: begin
            key_in = right_key;
            tag_in = right_tag;
         end
         default: begin
            key_in = key_ff;
            tag_in = tag_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

endmodule

/* hdl/sis_chain.sv */
// ----------------------------------------------------------------------------
// sis_chain
// Row of sorting cells kept in ascending key order; cell zero holds the
// smallest record and is the head of the output stream.
// ----------------------------------------------------------------------------
module sis_chain #(
   parameter int MAX_RECORDS = sis_pkg::DEFAULT_MAX_RECORDS,
   parameter int CNT_W       = $clog2(MAX_RECORDS + 1)
) (
   input  logic                             clock,
   input  sis_pkg::cell_ctrl_type           ctrl,
   input  logic [CNT_W-1:0]                 fill,
   output logic signed [sis_pkg::KEY_W-1:0] head_key,
   output logic        [sis_pkg::TAG_W-1:0] head_tag
);
   import sis_pkg::*;

   logic                    gt_w  [MAX_RECORDS];
   logic signed [KEY_W-1:0] key_w [MAX_RECORDS];
   logic        [TAG_W-1:0] tag_w [MAX_RECORDS];
   logic                    occ_w [MAX_RECORDS];

   assign head_key = key_w[0];
   assign head_tag = tag_w[0];

   // Build the row; cell zero has no left neighbor, the last cell no right
   for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
      logic                    lgt;
      logic signed [KEY_W-1:0] lkey, rkey;
      logic        [TAG_W-1:0] ltag, rtag;

      assign occ_w[g] = CNT_W'(g) < fill;

      if (g == 0) begin : g_first
         assign lgt  = 1'b0;
         assign lkey = key_w[g];
         assign ltag = tag_w[g];
      end else begin : g_mid_left
         assign lgt  = gt_w[g-1];
         assign lkey = key_w[g-1];
         assign ltag = tag_w[g-1];
      end

      if (g == MAX_RECORDS - 1) begin : g_last
         assign rkey = key_w[g];
         assign rtag = tag_w[g];
      end else begin : g_mid_right
         assign rkey = key_w[g+1];
         assign rtag = tag_w[g+1];
      end

      sis_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (occ_w[g]),
         .left_gt   (lgt),
         .left_key  (lkey),
         .left_tag  (ltag),
         .right_key (rkey),
         .right_tag (rtag),
         .gt        (gt_w[g]),
         .key       (key_w[g]),
         .tag       (tag_w[g])
      );
   end

endmodule

/* hdl/stable_insertion_sorter_core.sv */
// A record is inserted, or dropped if the store is full, in the cycle it is
// accepted, one per cycle while collecting. After the final record's transfer,
// the first result is offered in the next cycle, then one result per cycle while
// the sink is ready; each transfer shifts the cell row left toward cell zero, and
// no record is accepted during the drain. Reset clears the fill count, overflow
// flag and controller state; cell contents are not cleared.
// ----------------------------------------------------------------------------
// stable_insertion_sorter_core
// Stable ascending insertion sorter built from a row of cells with a
// broadcast insert and a shift-out drain through cell zero.
// ----------------------------------------------------------------------------
module stable_insertion_sorter_core #(
   parameter int MAX_RECORDS = sis_pkg::DEFAULT_MAX_RECORDS
) (
   input  logic        clock,
   input  logic        reset,
   sis_req_if.sink     req,
   sis_rsp_if.source   rsp
);
   import sis_pkg::*;

   localparam int CNT_W = $clog2(MAX_RECORDS + 1);

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic                    dropped_ff, dropped_in;
   cell_ctrl_type           ctrl;
   logic signed [KEY_W-1:0] head_key;
   logic        [TAG_W-1:0] head_tag;
   logic                    req_xfer, rsp_xfer, full;

   assign req_xfer = req.valid && req.ready;
   assign rsp_xfer = rsp.valid && rsp.ready;
   assign full     = fill_ff == CNT_W'(MAX_RECORDS);

   // Offer the head cell during the drain
   assign rsp.payload.sorted_key = head_key;
   assign rsp.payload.sorted_tag = head_tag;
   assign rsp.payload.end_of_set = fill_ff == CNT_W'(1);
   assign rsp.payload.overflowed = dropped_ff;

   // Next state, fill count and cell operation
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      dropped_in   = dropped_ff;
      ctrl.op      = OP_HOLD;
      ctrl.new_key = req.payload.sort_key;
      ctrl.new_tag = req.payload.payload_tag;
      req.ready    = 1'b0;
      rsp.valid    = 1'b0;
      unique case (state_ff)
         ST_COLLECT: begin
            req.ready = 1'b1;
            if (req_xfer) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  ctrl.op = OP_INSERT;
                  fill_in = fill_ff + CNT_W'(1);
               end
               if (req.payload.is_final) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            rsp.valid = 1'b1;
            if (rsp_xfer) begin
               ctrl.op = OP_SHIFT_OUT;
               fill_in = fill_ff - CNT_W'(1);
               if (fill_ff == CNT_W'(1)) begin
                  state_in   = ST_COLLECT;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_COLLECT;
         fill_ff    <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         dropped_ff <= dropped_in;
      end
   end

   sis_chain #(
      .MAX_RECORDS (MAX_RECORDS),
      .CNT_W       (CNT_W)
   ) u_chain (
      .clock    (clock),
      .ctrl     (ctrl),
      .fill     (fill_ff),
      .head_key (head_key),
      .head_tag (head_tag)
   );

   // Never offer a result from an empty store
   a_rsp_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> fill_ff != '0)
      else $error("result offered with empty store");

   // A record arriving at a full store raises the overflow flag
   a_drop_flag: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && full) |=> dropped_ff)
      else $error("dropped record not flagged");

   // The end-of-set transfer closes the burst
   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp.payload.end_of_set) |=> (!rsp.valid && fill_ff == '0 && !dropped_ff))
      else $error("burst continued after end of set");

   // Fill count stays within the row
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(MAX_RECORDS))
      else $error("fill count beyond capacity");

endmodule

/* tb/tb_stable_insertion_sorter_core.sv */
// ----------------------------------------------------------------------------
// tb_stable_insertion_sorter_core
// Self-checking bench for the stable insertion sorter. Records go in over the
// request channel and a queue-based sorting predictor builds the expected
// output of each set. Sorted records are checked field by field as they are
// transferred out. Both channels idle at random, and one phase stalls the
// output long enough for the next set to back up into the input.
// ----------------------------------------------------------------------------
module tb_stable_insertion_sorter_core;
   import sis_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_RECORDS  = DEFAULT_MAX_RECORDS;
   localparam int LIMIT_CYCLES = 60000;

   typedef struct {
      logic signed [KEY_W-1:0] key;
      logic        [TAG_W-1:0] tag;
   } stored_record_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sis_req_if req_if ();
   sis_rsp_if rsp_if ();

   stable_insertion_sorter_core #(
      .MAX_RECORDS (MAX_RECORDS)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // Predictor state: records of the open set in sorted order, drop flag
   stored_record_type sorted_store[$];
   logic              records_dropped = 1'b0;
   rsp_payload_type   sorted_records_due[$];

   int send_gap_max     = 0;
   int recv_stall_max   = 0;
   int rsp_hold_cycles  = 0;
   int cycle_count      = 0;
   int fail_count       = 0;
   int records_sent     = 0;
   int sets_closed      = 0;
   int overflow_sets    = 0;
   int results_checked  = 0;

   always #4 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Give up on a hung run
   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("tb_stable_insertion_sorter_core: FAIL");
      $finish;
   end

   // Insert one record stably; on the final record emit the whole set
   function automatic void sort_into_store(req_payload_type rec);
      int              pos;
      rsp_payload_type due;
      if (sorted_store.size() >= MAX_RECORDS) begin
         records_dropped = 1'b1;
      end else begin
         pos = sorted_store.size();
         while (pos > 0 && sorted_store[pos-1].key > rec.sort_key) pos--;
         sorted_store.insert(pos, '{key: rec.sort_key, tag: rec.payload_tag});
      end
      if (rec.is_final) begin
         foreach (sorted_store[i]) begin
            due.sorted_key = sorted_store[i].key;
            due.sorted_tag = sorted_store[i].tag;
            due.end_of_set = (i == sorted_store.size() - 1);
            due.overflowed = records_dropped;
            sorted_records_due.push_back(due);
         end
         sets_closed++;
         if (records_dropped) overflow_sets++;
         sorted_store.delete();
         records_dropped = 1'b0;
      end
   endfunction

   // Offer one record after a random gap and hold it until the transfer
   task automatic send_record(input logic signed [KEY_W-1:0] key,
                              input logic [TAG_W-1:0] tag, input logic fin);
      int              gap;
      req_payload_type rec;
      rec.sort_key    = key;
      rec.payload_tag = tag;
      rec.is_final    = fin;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= rec;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sort_into_store(rec);
      records_sent++;
   endtask

   function automatic logic signed [KEY_W-1:0] random_key();
      case ($urandom_range(0, 3))
         0:       return KEY_W'($signed($urandom_range(0, 6)) - 3);
         1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         default: return KEY_W'($urandom);
      endcase
   endfunction

   // Send one set of random records, the last one marked final
   task automatic send_random_set(input int count);
      for (int i = 0; i < count; i++) begin
         send_record(random_key(), TAG_W'($urandom), i == count - 1);
      end
   endtask

   // Compare one transferred result with the oldest expectation
   task automatic check_sorted_record(input rsp_payload_type got);
      rsp_payload_type due;
      if (sorted_records_due.size() == 0) begin
         $error("unexpected result: key %0d tag 0x%04h", got.sorted_key, got.sorted_tag);
         fail_count++;
      end else begin
         due = sorted_records_due.pop_front();
         results_checked++;
         if (got.sorted_key !== due.sorted_key) begin
            $error("sorted_key: expected %0d, got %0d", due.sorted_key, got.sorted_key);
            fail_count++;
         end
         if (got.sorted_tag !== due.sorted_tag) begin
            $error("sorted_tag: expected 0x%04h, got 0x%04h", due.sorted_tag, got.sorted_tag);
            fail_count++;
         end
         if (got.end_of_set !== due.end_of_set) begin
            $error("end_of_set: expected %0b, got %0b", due.end_of_set, got.end_of_set);
            fail_count++;
         end
         if (got.overflowed !== due.overflowed) begin
            $error("overflowed: expected %0b, got %0b", due.overflowed, got.overflowed);
            fail_count++;
         end
      end
   endtask

   // Result side: stall at random, or for a requested long hold, then take one
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      wait (!reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = $urandom_range(0, recv_stall_max);
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         check_sorted_record(rsp_if.payload);
      end
   end

   // Sets of one record, including the key and tag extremes
   task automatic test_single_record_sets();
      send_record(16'sh0000, 16'h1234, 1'b1);
      send_record(16'sh8000, 16'hFFFF, 1'b1);
      send_record(16'sh7FFF, 16'h0000, 1'b1);
   endtask

   // Keys across the whole signed range, arriving out of order
   task automatic test_key_extremes();
      send_record(16'sh7FFF, 16'hAAAA, 1'b0);
      send_record(16'sh8000, 16'h5555, 1'b0);
      send_record(16'sh0000, 16'h0001, 1'b0);
      send_record(16'shFFFF, 16'h8000, 1'b0);
      send_record(16'sh0001, 16'h7FFF, 1'b0);
      send_record(16'sh4000, 16'h00FF, 1'b0);
      send_record(16'shC000, 16'hFF00, 1'b1);
   endtask

   // Equal keys keep their arrival order
   task automatic test_equal_keys();
      send_record(16'sh0064, 16'h0001, 1'b0);
      send_record(16'sh0064, 16'h0002, 1'b0);
      send_record(16'shFFFB, 16'h0003, 1'b0);
      send_record(16'sh0064, 16'h0004, 1'b0);
      send_record(16'shFFFB, 16'h0005, 1'b0);
      send_record(16'sh0064, 16'h0006, 1'b1);
   endtask

   // Small random sets under changing idle settings
   task automatic test_random_sets();
      int start;
      start = records_sent;
      while (records_sent - start < 12) begin
         send_gap_max   = $urandom_range(0, 1) ? 5 : 0;
         recv_stall_max = $urandom_range(0, 1) ? 5 : 0;
         send_random_set($urandom_range(1, 6));
      end
   endtask

   // No idling: final records follow each drain at once
   task automatic test_back_to_back();
      send_gap_max   = 0;
      recv_stall_max = 0;
      for (int i = 0; i < 6; i++) send_random_set($urandom_range(1, 2));
   endtask

   // Stall the output through a drain so the next set backs up at the input
   task automatic test_output_stall();
      send_gap_max    = 0;
      recv_stall_max  = 5;
      rsp_hold_cycles = 150;
      send_random_set(8);
      send_random_set(2);
   endtask

   // One record past capacity; the dropped one is the final record
   task automatic test_store_overflow();
      send_gap_max   = 2;
      recv_stall_max = 3;
      send_random_set(MAX_RECORDS + 1);
      send_random_set(3);
   endtask

   initial begin
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_record_sets();
      send_gap_max   = 3;
      recv_stall_max = 3;
      test_key_extremes();
      test_equal_keys();
      test_random_sets();
      test_back_to_back();
      test_output_stall();
      test_store_overflow();

      // Drop valid, wait for every result, then let the block settle
      req_if.valid <= 1'b0;
      while (sorted_records_due.size() > 0) @(posedge clock);
      repeat (MAX_RECORDS + 8) @(posedge clock);

      $display("Covered %0d records in %0d sets (%0d with overflow), %0d results checked.",
               records_sent, sets_closed, overflow_sets, results_checked);
      $display("Included key extremes, equal keys, a full store and a long output stall.");
      if (fail_count == 0) begin
         $display("tb_stable_insertion_sorter_core: PASS");
      end else begin
         $display("tb_stable_insertion_sorter_core: FAIL");
      end
      $finish;
   end

endmodule
